FILE: rtl/imu_dfr_pkg.sv
// ----------------------------------------------------------------------------
// IMU datagram deframer package
// Shared types and fixed constants of the byte-stream frame parser.
// ----------------------------------------------------------------------------
package imu_dfr_pkg;

  // Register reset value of the start-of-frame byte
  localparam logic [7:0] HEADER_RESET = 8'h93;

  // Width of the frame byte counter
  localparam int unsigned POS_W = 6;

  // Frame byte indexes of the three status bytes
  localparam int unsigned STATUS_A = 10;
  localparam int unsigned STATUS_B = 20;
  localparam int unsigned STATUS_C = 30;

  // Number of 24-bit values in one result item
  localparam int unsigned NUM_OUT = 9;

  // Frame byte index of the most significant byte of each value
  localparam int unsigned FIELD_START [NUM_OUT] = '{1, 4, 7, 11, 14, 17, 21, 24, 27};

  // Frame parser states
  typedef enum logic {
    ST_HUNT  = 1'b0,
    ST_FRAME = 1'b1
  } dfr_state_e;

  // Controls from the frame sequencer to the datapath
  typedef struct packed {
    logic shift;      // move the accepted byte into the cell chain
    logic frame_end;  // accepted byte is the last byte of a frame
  } dfr_ctrl_t;

endpackage

FILE: rtl/imu_dfr_cell.sv
// ----------------------------------------------------------------------------
// IMU datagram byte cell
// One byte stage of the frame chain; hands its byte to the next cell on shift.
// ----------------------------------------------------------------------------
module imu_dfr_cell (
  input  logic       clk_i,
  input  logic       shift_i,
  input  logic [7:0] byte_i,
  output logic [7:0] byte_o
);

  logic [7:0] byte_q;
  logic [7:0] byte_d;

  // Take the neighbor's byte on shift, else hold
  assign byte_d = shift_i ? byte_i : byte_q;

  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
  end

  assign byte_o = byte_q;

endmodule

FILE: rtl/imu_dfr_seq.sv
// ----------------------------------------------------------------------------
// IMU datagram frame sequencer
// Hunts for the header byte and counts the bytes of one frame.
// ----------------------------------------------------------------------------
module imu_dfr_seq
  import imu_dfr_pkg::*;
#(
  parameter int unsigned FRAME_LENGTH = 38
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       accept_i,
  input  logic [7:0] rx_byte_i,
  input  logic [7:0] header_i,
  output dfr_ctrl_t  ctrl_o
);

  localparam logic [POS_W-1:0] LastPrev = POS_W'(FRAME_LENGTH - 2);

  dfr_state_e       state_q, state_d;
  logic [POS_W-1:0] pos_q, pos_d;
  logic             hdr_hit;
  logic             last_byte;

  assign hdr_hit   = (rx_byte_i == header_i);
  assign last_byte = (pos_q == LastPrev);

  // Next state and byte position
  always_comb begin
    state_d = state_q;
    pos_d   = pos_q;
    unique case (state_q)
      ST_HUNT: begin
        if (accept_i && hdr_hit) begin
          state_d = ST_FRAME;
          pos_d   = '0;
        end
      end
      ST_FRAME: begin
        if (accept_i) begin
          pos_d = pos_q + POS_W'(1);
          if (last_byte) begin
            state_d = ST_HUNT;
          end
        end
      end
      default: begin
        state_d = ST_HUNT;
      end
    endcase
  end

  // Datapath controls
  always_comb begin
    ctrl_o = '0;
    unique case (state_q)
      ST_HUNT: begin
        ctrl_o.shift = accept_i && hdr_hit;
      end
      ST_FRAME: begin
        ctrl_o.shift     = accept_i;
        ctrl_o.frame_end = accept_i && last_byte;
      end
      default: begin
        ctrl_o = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_HUNT;
      pos_q   <= '0;
    end else begin
      state_q <= state_d;
      pos_q   <= pos_d;
    end
  end

endmodule

FILE: rtl/imu_datagram_deframer_top.sv
// ----------------------------------------------------------------------------
// IMU datagram deframer
// Parses fixed-length sensor frames from a byte stream into nine 24-bit values.
// ----------------------------------------------------------------------------
//  Channel  Direction  Handshake                  Payload
//  in       sink       in_valid_i / in_stall_o    rx_byte_i
//  out      source     out_valid_o / out_stall_i  rate_*, accel_*, tilt_*
//  cfg      sink       cfg_valid_i / cfg_ready_o  cfg_data_i (header byte)
//
//  One byte is accepted per cycle unless the input stalls; a result appears in
//  the cycle after the last byte of a good frame is accepted.
//  The rate is set by the byte cell chain, which shifts once per accepted frame byte.
//  The input stalls only while a finished result waits and the sink stalls.
//  Reset clears the sequencer to hunting and the header byte to 0x93.
// ----------------------------------------------------------------------------
module imu_datagram_deframer_top
  import imu_dfr_pkg::*;
#(
  parameter int unsigned FRAME_LENGTH = 38
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic        [ 7:0] cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic        [ 7:0] rx_byte_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [23:0] rate_x_o,
  output logic signed [23:0] rate_y_o,
  output logic signed [23:0] rate_z_o,
  output logic signed [23:0] accel_x_o,
  output logic signed [23:0] accel_y_o,
  output logic signed [23:0] accel_z_o,
  output logic signed [23:0] tilt_x_o,
  output logic signed [23:0] tilt_y_o,
  output logic signed [23:0] tilt_z_o
);

  localparam int unsigned NumCells = FRAME_LENGTH - 1;

  logic [7:0]  header_q;
  logic        accept;
  dfr_ctrl_t   ctrl;
  logic [7:0]  chain [NumCells+1];
  logic [7:0]  window [STATUS_C+1];
  logic        status_ok;
  logic [23:0] field [NUM_OUT];
  logic [23:0] res_q [NUM_OUT];
  logic        out_valid_q, out_valid_d;
  logic        load;

  // Configuration: header byte register
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      header_q <= HEADER_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      header_q <= cfg_data_i;
    end
  end

  // Input handshake
  assign in_stall_o = out_valid_q && out_stall_i;
  assign accept     = in_valid_i && !in_stall_o;

  imu_dfr_seq #(
    .FRAME_LENGTH(FRAME_LENGTH)
  ) u_seq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .rx_byte_i(rx_byte_i),
    .header_i (header_q),
    .ctrl_o   (ctrl)
  );

  // Byte chain: cell 0 holds the newest byte
  assign chain[0] = rx_byte_i;

  for (genvar c = 0; c < NumCells; c++) begin : g_cell
    imu_dfr_cell u_cell (
      .clk_i  (clk_i),
      .shift_i(ctrl.shift),
      .byte_i (chain[c]),
      .byte_o (chain[c+1])
    );
  end

  // Frame view at the last byte: frame byte j sits FRAME_LENGTH-1-j deep
  for (genvar j = 0; j < STATUS_C + 1; j++) begin : g_win
    assign window[j] = chain[FRAME_LENGTH-1-j];
  end

  assign status_ok = (window[STATUS_A] == 8'h00) && (window[STATUS_B] == 8'h00)
                  && (window[STATUS_C] == 8'h00);

  // Assemble big-endian values
  for (genvar k = 0; k < NUM_OUT; k++) begin : g_field
    assign field[k] = {window[FIELD_START[k]], window[FIELD_START[k]+1],
                       window[FIELD_START[k]+2]};
  end

  // Output register
  assign load = ctrl.frame_end && status_ok;

  always_comb begin
    if (load) begin
      out_valid_d = 1'b1;
    end else if (out_stall_i) begin
      out_valid_d = out_valid_q;
    end else begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      res_q <= field;
    end
  end

  assign out_valid_o = out_valid_q;
  assign rate_x_o    = $signed(res_q[0]);
  assign rate_y_o    = $signed(res_q[1]);
  assign rate_z_o    = $signed(res_q[2]);
  assign accel_x_o   = $signed(res_q[3]);
  assign accel_y_o   = $signed(res_q[4]);
  assign accel_z_o   = $signed(res_q[5]);
  assign tilt_x_o    = $signed(res_q[6]);
  assign tilt_y_o    = $signed(res_q[7]);
  assign tilt_z_o    = $signed(res_q[8]);

endmodule

FILE: rtl/imu_dfr_checker.sv
// ----------------------------------------------------------------------------
// IMU datagram deframer checker
// Port-level properties of the deframer, bound to the top level.
// ----------------------------------------------------------------------------
module imu_dfr_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_stall_o,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input logic signed [23:0] rate_x_o,
  input logic signed [23:0] tilt_z_o
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // Keep a stalled payload stable (rate_x and tilt_z are checked)
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(rate_x_o) && $stable(tilt_z_o))
    else $error("result payload changed while stalled");

  // Stall input only behind a blocked result
  a_in_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without a blocked result");

  // A new result follows an accepted byte
  a_out_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && !in_stall_o))
    else $error("result without an accepted item");

endmodule

bind imu_datagram_deframer_top imu_dfr_checker u_imu_dfr_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_valid_i),
  .in_stall_o (in_stall_o),
  .out_valid_o(out_valid_o),
  .out_stall_i(out_stall_i),
  .rate_x_o   (rate_x_o),
  .tilt_z_o   (tilt_z_o)
);
